// File: rtl/nsfp_pkg.sv
// Package for the NMEA sentence field parser: header codes, table ids,
// event codes, result struct and header decode function. No dependencies.
package nsfp_pkg;

    // Field store geometry
    localparam int FIELD_LEN = 16;
    localparam int CHAR_W    = $clog2(FIELD_LEN);
    localparam logic [CHAR_W-1:0] CC_LAST = CHAR_W'(FIELD_LEN - 1);

    // Sentence headers, first received byte in the low octet
    localparam logic [31:0] HDR_PRMC = 32'h434D5250;
    localparam logic [31:0] HDR_NRMC = 32'h434D524E;
    localparam logic [31:0] HDR_PGGA = 32'h41474750;
    localparam logic [31:0] HDR_NGGA = 32'h4147474E;
    localparam logic [31:0] HDR_PVTG = 32'h47545650;
    localparam logic [31:0] HDR_NVTG = 32'h4754564E;
    localparam logic [31:0] HDR_PGSV = 32'h56534750;
    localparam logic [31:0] HDR_LGSV = 32'h5653474C;

    // Idle marker for byte counter and field number
    localparam logic [7:0] IDLE_MARK = 8'hFF;

    // Characters of interest
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    // Field that carries the satellite count in GSV
    localparam logic [7:0] GSV_SATS_FIELD = 8'd2;

    typedef enum logic [1:0] {
        TBL_RMC = 2'd0,
        TBL_GGA = 2'd1,
        TBL_VTG = 2'd2,
        TBL_GSV = 2'd3
    } t_table;

    typedef enum logic [2:0] {
        EV_NONE = 3'd0,
        EV_RMC  = 3'd1,
        EV_GGA  = 3'd2,
        EV_PVTG = 3'd3,
        EV_NVTG = 3'd4,
        EV_PGSV = 3'd5,
        EV_LGSV = 3'd6
    } t_event;

    typedef struct packed {
        logic   known;
        t_table tid;
        t_event done;
    } t_hdr;

    // One result item
    typedef struct packed {
        t_event      event_res;
        logic        write_valid;
        logic        field_clear;
        t_table      table_id;
        logic [4:0]  field_index;
        logic [3:0]  char_pos;
        logic [7:0]  char_value;
        logic [7:0]  gps_sats;
        logic [7:0]  glonass_sats;
    } t_result;

    // Number of fields held per table
    function automatic logic [7:0] tbl_fields(input t_table tid);
        logic [7:0] n;
        case (tid)
            TBL_RMC: n = 8'd14;
            TBL_GGA: n = 8'd16;
            TBL_VTG: n = 8'd10;
            TBL_GSV: n = 8'd21;
            default: n = 8'd0;
        endcase
        return n;
    endfunction

    // Header word to table and completion event
    function automatic t_hdr hdr_decode(input logic [31:0] hw);
        t_hdr h;
        h.known = 1'b1;
        h.tid   = TBL_RMC;
        h.done  = EV_NONE;
        case (hw)
            HDR_PRMC, HDR_NRMC: begin h.tid = TBL_RMC; h.done = EV_RMC;  end
            HDR_PGGA, HDR_NGGA: begin h.tid = TBL_GGA; h.done = EV_GGA;  end
            HDR_PVTG:           begin h.tid = TBL_VTG; h.done = EV_PVTG; end
            HDR_NVTG:           begin h.tid = TBL_VTG; h.done = EV_NVTG; end
            HDR_PGSV:           begin h.tid = TBL_GSV; h.done = EV_PGSV; end
            HDR_LGSV:           begin h.tid = TBL_GSV; h.done = EV_LGSV; end
            default:            h.known = 1'b0;
        endcase
        return h;
    endfunction

endpackage

// File: rtl/nsfp_if.sv
// Valid/ready channel interfaces for received bytes and parser results.
// No dependencies.
interface nsfp_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface nsfp_res_if;
    logic       valid;
    logic       ready;
    logic [2:0] event_res;
    logic       write_valid;
    logic       field_clear;
    logic [1:0] table_id;
    logic [4:0] field_index;
    logic [3:0] char_pos;
    logic [7:0] char_value;
    logic [7:0] gps_sats;
    logic [7:0] glonass_sats;

    modport source (output valid, output event_res, output write_valid,
                    output field_clear, output table_id, output field_index,
                    output char_pos, output char_value, output gps_sats,
                    output glonass_sats, input ready);
    modport sink   (input valid, input event_res, input write_valid,
                    input field_clear, input table_id, input field_index,
                    input char_pos, input char_value, input gps_sats,
                    input glonass_sats, output ready);
endinterface

// File: rtl/nsfp_in_reg.sv
// Input register stage: captures one received byte per item.
// Depends on nsfp_if.
module nsfp_in_reg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    nsfp_rx_if.sink       i_rx,
    input  logic          i_take,
    output logic          o_valid,
    output logic [7:0]    o_byte
);

    logic       r_valid;
    logic [7:0] r_byte;

    // Free when empty or when the held byte moves on this cycle
    assign i_rx.ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_valid <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_byte <= i_rx.rx_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

endmodule

// File: rtl/nsfp_parse.sv
// Sentence state and per-byte parse logic; state advances on i_fire.
// Depends on nsfp_pkg.
module nsfp_parse (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  logic [7:0]        i_byte,
    output nsfp_pkg::t_result o_result
);

    logic [7:0]                  r_bc,  n_bc;
    logic [31:0]                 r_hdr, n_hdr;
    logic [7:0]                  r_fn,  n_fn;
    logic [nsfp_pkg::CHAR_W-1:0] r_cc,  n_cc;
    logic [7:0]                  r_acc, n_acc;
    logic                        r_open, n_open;
    logic [7:0]                  r_gps, n_gps;
    logic [7:0]                  r_glo, n_glo;

    logic [7:0]                  bc_inc;
    logic [7:0]                  fn_inc;
    logic [7:0]                  limit;
    logic [11:0]                 dec_sum;
    logic [nsfp_pkg::CHAR_W+3:0] pos_ext;
    nsfp_pkg::t_hdr              hdr;
    nsfp_pkg::t_result           res;

    assign bc_inc  = r_bc + 8'd1;
    assign fn_inc  = r_fn + 8'd1;
    assign hdr     = nsfp_pkg::hdr_decode(r_hdr);
    assign limit   = nsfp_pkg::tbl_fields(hdr.tid);
    assign pos_ext = {4'b0, r_cc};
    // acc*10 + digit; the digit is the low nibble of an ASCII numeral
    assign dec_sum = ({4'b0, r_acc} << 3) + ({4'b0, r_acc} << 1) + {8'b0, i_byte[3:0]};

    // Next state and result for the byte in the input register
    always_comb begin
        n_bc   = r_bc;
        n_hdr  = r_hdr;
        n_fn   = r_fn;
        n_cc   = r_cc;
        n_acc  = r_acc;
        n_open = r_open;
        n_gps  = r_gps;
        n_glo  = r_glo;
        res    = '0;

        if (i_byte == nsfp_pkg::CH_DOLLAR) begin
            n_bc = 8'd0;
            n_fn = nsfp_pkg::IDLE_MARK;
        end else if (r_bc != nsfp_pkg::IDLE_MARK) begin
            n_bc = bc_inc;
            if (bc_inc >= 8'd2 && bc_inc <= 8'd5) begin
                // Header bytes, first byte in the low octet
                case (bc_inc[1:0])
                    2'b10:   n_hdr[7:0]   = i_byte;
                    2'b11:   n_hdr[15:8]  = i_byte;
                    2'b00:   n_hdr[23:16] = i_byte;
                    default: n_hdr[31:24] = i_byte;
                endcase
            end else if (bc_inc > 8'd5) begin
                if (!hdr.known) begin
                    n_bc = nsfp_pkg::IDLE_MARK;
                end else begin
                    res.table_id = hdr.tid;
                    if (i_byte == nsfp_pkg::CH_COMMA) begin
                        // Open the next field
                        n_fn = fn_inc;
                        n_cc = '0;
                        if (fn_inc < limit) begin
                            res.field_clear = 1'b1;
                            res.field_index = fn_inc[4:0];
                            if (hdr.tid == nsfp_pkg::TBL_GSV &&
                                fn_inc == nsfp_pkg::GSV_SATS_FIELD) begin
                                n_acc  = 8'd0;
                                n_open = 1'b1;
                            end
                        end
                    end else if (i_byte == nsfp_pkg::CH_STAR) begin
                        // Sentence complete
                        res.event_res = hdr.done;
                        if (hdr.tid != nsfp_pkg::TBL_VTG) begin
                            n_hdr = 32'd0;
                        end
                        if (hdr.done == nsfp_pkg::EV_PGSV) begin
                            n_gps = r_acc;
                        end else if (hdr.done == nsfp_pkg::EV_LGSV) begin
                            n_glo = r_acc;
                        end
                    end else if (r_fn < limit && r_cc < nsfp_pkg::CC_LAST) begin
                        // Character write, room kept for the terminator
                        res.write_valid = 1'b1;
                        res.field_index = r_fn[4:0];
                        res.char_pos    = pos_ext[3:0];
                        res.char_value  = i_byte;
                        n_cc = r_cc + {{(nsfp_pkg::CHAR_W-1){1'b0}}, 1'b1};
                        if (hdr.tid == nsfp_pkg::TBL_GSV &&
                            r_fn == nsfp_pkg::GSV_SATS_FIELD && r_open) begin
                            if (i_byte >= nsfp_pkg::CH_ZERO &&
                                i_byte <= nsfp_pkg::CH_NINE) begin
                                n_acc = (dec_sum > 12'd255) ? 8'hFF : dec_sum[7:0];
                            end else begin
                                n_open = 1'b0;
                            end
                        end
                    end
                end
            end
        end

        res.gps_sats     = n_gps;
        res.glonass_sats = n_glo;
    end

    // Sentence state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bc   <= nsfp_pkg::IDLE_MARK;
            r_hdr  <= 32'd0;
            r_fn   <= nsfp_pkg::IDLE_MARK;
            r_cc   <= '0;
            r_acc  <= 8'd0;
            r_open <= 1'b0;
            r_gps  <= 8'd0;
            r_glo  <= 8'd0;
        end else if (i_fire) begin
            r_bc   <= n_bc;
            r_hdr  <= n_hdr;
            r_fn   <= n_fn;
            r_cc   <= n_cc;
            r_acc  <= n_acc;
            r_open <= n_open;
            r_gps  <= n_gps;
            r_glo  <= n_glo;
        end
    end

    assign o_result = res;

endmodule

// File: rtl/nsfp_out_reg.sv
// Result register stage driving the result channel.
// Depends on nsfp_pkg and nsfp_if.
module nsfp_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  nsfp_pkg::t_result i_result,
    output logic              o_fire,
    nsfp_res_if.source        o_res
);

    logic              r_valid;
    nsfp_pkg::t_result r_res;
    logic              can_load;

    // Load when empty or when the held item leaves this cycle
    assign can_load = !r_valid || o_res.ready;
    assign o_fire   = i_valid && can_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (can_load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_fire) begin
            r_res <= i_result;
        end
    end

    assign o_res.valid        = r_valid;
    assign o_res.event_res    = r_res.event_res;
    assign o_res.write_valid  = r_res.write_valid;
    assign o_res.field_clear  = r_res.field_clear;
    assign o_res.table_id     = r_res.table_id;
    assign o_res.field_index  = r_res.field_index;
    assign o_res.char_pos     = r_res.char_pos;
    assign o_res.char_value   = r_res.char_value;
    assign o_res.gps_sats     = r_res.gps_sats;
    assign o_res.glonass_sats = r_res.glonass_sats;

endmodule

// File: rtl/nmea_sentence_field_parser_core.sv
// NMEA sentence field parser, one received byte per item, one result per item.
// A byte taken into the input register is parsed combinationally and its result is loaded into the result register.
// Throughput: one byte per cycle while the result channel is ready, set by the state update in nsfp_parse.
// Reset (i_rst_n low, synchronous): both stages empty, parser idle until a '$',
// satellite counts zero.
module nmea_sentence_field_parser_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    nsfp_rx_if.sink    i_rx,
    nsfp_res_if.source o_res
);

    logic              in_valid;
    logic [7:0]        in_byte;
    logic              fire;
    nsfp_pkg::t_result result;

    // Input register
    nsfp_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (i_rx),
        .i_take  (fire),
        .o_valid (in_valid),
        .o_byte  (in_byte)
    );

    // Parse logic and sentence state
    nsfp_parse u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_byte   (in_byte),
        .o_result (result)
    );

    // Result register
    nsfp_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (in_valid),
        .i_result (result),
        .o_fire   (fire),
        .o_res    (o_res)
    );

endmodule

// File: bench/tb_nmea_sentence_field_parser_core.sv
// Testbench for nmea_sentence_field_parser_core: feeds NMEA byte streams and checks
// every result item against a local parser model. Depends on nsfp_pkg, the nsfp_rx_if
// and nsfp_res_if interfaces, and the core itself.
module tb_nmea_sentence_field_parser_core;

    localparam int CLK_HALF    = 6;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_ITEMS = 170;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    nsfp_rx_if  rx_ch ();
    nsfp_res_if res_ch ();

    nmea_sentence_field_parser_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_ch),
        .o_res   (res_ch)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Bytes waiting to be sent and results the parser model expects
    logic [7:0]        stream_q[$];
    nsfp_pkg::t_result parse_results_q[$];

    int send_idle_pct  = 25;
    int recv_stall_pct = 50;
    int mismatch_count = 0;
    int cycle_count    = 0;
    int queued_bytes   = 0;

    // Parser model state
    logic [7:0]  byte_cnt  = nsfp_pkg::IDLE_MARK;
    logic [31:0] hdr_word  = '0;
    logic [7:0]  fld_num   = nsfp_pkg::IDLE_MARK;
    logic [7:0]  chars     = '0;
    logic [7:0]  sats_acc  = '0;
    logic        digit_run = 1'b0;
    logic [7:0]  gps_cnt   = '0;
    logic [7:0]  glo_cnt   = '0;

    logic [31:0] known_hdrs[8] = '{nsfp_pkg::HDR_PRMC, nsfp_pkg::HDR_NRMC,
                                   nsfp_pkg::HDR_PGGA, nsfp_pkg::HDR_NGGA,
                                   nsfp_pkg::HDR_PVTG, nsfp_pkg::HDR_NVTG,
                                   nsfp_pkg::HDR_PGSV, nsfp_pkg::HDR_LGSV};

    // Advance the parser model by one received byte and return its result item
    function automatic nsfp_pkg::t_result parse_byte(input logic [7:0] b);
        nsfp_pkg::t_result r;
        logic              known;
        nsfp_pkg::t_table  tbl;
        nsfp_pkg::t_event  done_ev;
        logic [7:0]        nfields;
        int                n;
        r = '0;
        if (b == nsfp_pkg::CH_DOLLAR) begin
            byte_cnt = 8'd0;
            fld_num  = nsfp_pkg::IDLE_MARK;
        end else if (byte_cnt != nsfp_pkg::IDLE_MARK) begin
            byte_cnt = byte_cnt + 8'd1;
            if (byte_cnt >= 8'd2 && byte_cnt <= 8'd5) begin
                n = 8 * (int'(byte_cnt) - 2);
                hdr_word[n +: 8] = b;
            end else if (byte_cnt > 8'd5) begin
                known   = 1'b1;
                tbl     = nsfp_pkg::TBL_RMC;
                done_ev = nsfp_pkg::EV_NONE;
                case (hdr_word)
                    nsfp_pkg::HDR_PRMC, nsfp_pkg::HDR_NRMC: begin
                        tbl = nsfp_pkg::TBL_RMC; done_ev = nsfp_pkg::EV_RMC;
                    end
                    nsfp_pkg::HDR_PGGA, nsfp_pkg::HDR_NGGA: begin
                        tbl = nsfp_pkg::TBL_GGA; done_ev = nsfp_pkg::EV_GGA;
                    end
                    nsfp_pkg::HDR_PVTG: begin
                        tbl = nsfp_pkg::TBL_VTG; done_ev = nsfp_pkg::EV_PVTG;
                    end
                    nsfp_pkg::HDR_NVTG: begin
                        tbl = nsfp_pkg::TBL_VTG; done_ev = nsfp_pkg::EV_NVTG;
                    end
                    nsfp_pkg::HDR_PGSV: begin
                        tbl = nsfp_pkg::TBL_GSV; done_ev = nsfp_pkg::EV_PGSV;
                    end
                    nsfp_pkg::HDR_LGSV: begin
                        tbl = nsfp_pkg::TBL_GSV; done_ev = nsfp_pkg::EV_LGSV;
                    end
                    default: known = 1'b0;
                endcase
                case (tbl)
                    nsfp_pkg::TBL_RMC: nfields = 8'd14;
                    nsfp_pkg::TBL_GGA: nfields = 8'd16;
                    nsfp_pkg::TBL_VTG: nfields = 8'd10;
                    default:           nfields = 8'd21;
                endcase
                if (!known) begin
                    byte_cnt = nsfp_pkg::IDLE_MARK;
                end else begin
                    r.table_id = tbl;
                    if (b == nsfp_pkg::CH_COMMA) begin
                        fld_num = fld_num + 8'd1;
                        chars   = 8'd0;
                        if (fld_num < nfields) begin
                            r.field_clear = 1'b1;
                            r.field_index = fld_num[4:0];
                            if (tbl == nsfp_pkg::TBL_GSV &&
                                fld_num == nsfp_pkg::GSV_SATS_FIELD) begin
                                sats_acc  = 8'd0;
                                digit_run = 1'b1;
                            end
                        end
                    end else if (b == nsfp_pkg::CH_STAR) begin
                        r.event_res = done_ev;
                        if (tbl != nsfp_pkg::TBL_VTG)
                            hdr_word = '0;
                        if (done_ev == nsfp_pkg::EV_PGSV)
                            gps_cnt = sats_acc;
                        else if (done_ev == nsfp_pkg::EV_LGSV)
                            glo_cnt = sats_acc;
                    end else if (fld_num < nfields &&
                                 int'(chars) + 1 < nsfp_pkg::FIELD_LEN) begin
                        r.write_valid = 1'b1;
                        r.field_index = fld_num[4:0];
                        r.char_pos    = chars[3:0];
                        r.char_value  = b;
                        chars = chars + 8'd1;
                        // leading-digit run of the satellite count field
                        if (tbl == nsfp_pkg::TBL_GSV &&
                            fld_num == nsfp_pkg::GSV_SATS_FIELD && digit_run) begin
                            if (b >= nsfp_pkg::CH_ZERO && b <= nsfp_pkg::CH_NINE) begin
                                n = int'(sats_acc) * 10 + int'(b - nsfp_pkg::CH_ZERO);
                                sats_acc = (n > 255) ? 8'd255 : n[7:0];
                            end else begin
                                digit_run = 1'b0;
                            end
                        end
                    end
                end
            end
        end
        r.gps_sats     = gps_cnt;
        r.glonass_sats = glo_cnt;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] exp_v,
                                        input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
            mismatch_count++;
        end
    endfunction

    // Printable field text, never one of the framing characters
    function automatic logic [7:0] text_byte();
        logic [7:0] c;
        do
            c = 8'($urandom_range(32, 126));
        while (c == nsfp_pkg::CH_DOLLAR || c == nsfp_pkg::CH_COMMA ||
               c == nsfp_pkg::CH_STAR);
        return c;
    endfunction

    task automatic push_byte(input logic [7:0] b);
        stream_q.push_back(b);
        queued_bytes++;
    endtask

    task automatic push_str(input string s);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i]);
    endtask

    // One sentence: mostly well formed with random content, sometimes broken
    task automatic add_sentence();
        logic [31:0] hw;
        int          nf;
        int          len;
        int          pick;
        bit          is_gsv;
        push_byte(nsfp_pkg::CH_DOLLAR);
        pick = $urandom_range(0, 99);
        if (pick < 80)
            push_byte(($urandom_range(0, 1) != 0) ? "G" : "L");
        else
            push_byte(8'($urandom_range(0, 255)));
        pick = $urandom_range(0, 99);
        hw = known_hdrs[$urandom_range(0, 7)];
        if (pick >= 95)
            hw = $urandom;
        else if (pick >= 85)
            hw[8 * $urandom_range(0, 3) +: 8] = text_byte();
        is_gsv = (hw == nsfp_pkg::HDR_PGSV || hw == nsfp_pkg::HDR_LGSV);
        for (int k = 0; k < 4; k++)
            push_byte(hw[8 * k +: 8]);
        nf = ($urandom_range(0, 99) < 80) ? $urandom_range(0, 12)
                                          : $urandom_range(13, 24);
        if (is_gsv && nf < 3 && $urandom_range(0, 3) != 0)
            nf = 3 + $urandom_range(0, 4);
        for (int j = 0; j < nf; j++) begin
            push_byte(nsfp_pkg::CH_COMMA);
            pick = $urandom_range(0, 99);
            len = (pick < 80) ? $urandom_range(0, 6) :
                  (pick < 95) ? $urandom_range(7, 12) : $urandom_range(13, 18);
            if (is_gsv && j == 2) begin
                // satellite count: mostly digits, sometimes broken or oversized
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 6)
                                                  : $urandom_range(0, 3);
                for (int c = 0; c < len; c++) begin
                    if ($urandom_range(0, 9) == 0)
                        push_byte(text_byte());
                    else
                        push_byte(nsfp_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
                end
            end else begin
                for (int c = 0; c < len; c++)
                    push_byte(text_byte());
            end
        end
        pick = $urandom_range(0, 99);
        if (pick < 85) begin
            push_byte(nsfp_pkg::CH_STAR);
            push_byte(text_byte());
            push_byte(text_byte());
            push_str("\r\n");
        end else if (pick < 93) begin
            len = $urandom_range(1, 5);
            for (int c = 0; c < len; c++)
                push_byte(8'($urandom_range(0, 255)));
        end
    endtask

    // Block until every queued byte is sent and every expected item has come back
    task automatic wait_drained();
        while (stream_q.size() != 0 || rx_ch.valid || parse_results_q.size() != 0)
            @(negedge i_clk);
    endtask

    // Sender: offer the next byte, record the expected result on acceptance
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_ch.valid <= 1'b0;
        end else begin
            if (rx_ch.valid && rx_ch.ready)
                parse_results_q.push_back(parse_byte(rx_ch.rx_byte));
            if (!rx_ch.valid || rx_ch.ready) begin
                if (stream_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    rx_ch.valid   <= 1'b1;
                    rx_ch.rx_byte <= stream_q.pop_front();
                end else begin
                    rx_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random stalls, compare each accepted result item
    always @(posedge i_clk) begin
        nsfp_pkg::t_result exp_r;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (parse_results_q.size() == 0) begin
                $error("result item arrived with no expected entry");
                mismatch_count++;
            end else begin
                exp_r = parse_results_q.pop_front();
                check_field("event_res",    exp_r.event_res,    res_ch.event_res);
                check_field("write_valid",  exp_r.write_valid,  res_ch.write_valid);
                check_field("field_clear",  exp_r.field_clear,  res_ch.field_clear);
                check_field("table_id",     exp_r.table_id,     res_ch.table_id);
                check_field("field_index",  exp_r.field_index,  res_ch.field_index);
                check_field("char_pos",     exp_r.char_pos,     res_ch.char_pos);
                check_field("char_value",   exp_r.char_value,   res_ch.char_value);
                check_field("gps_sats",     exp_r.gps_sats,     res_ch.gps_sats);
                check_field("glonass_sats", exp_r.glonass_sats, res_ch.glonass_sats);
            end
        end
        res_ch.ready <= i_rst_n && ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Watchdog
    always @(posedge i_clk)
        cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("FAIL");
        $finish;
    end

    // Stimulus and end of run
    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: ignored bytes while idle, saturated count, VTG past '*',
        // write before first comma, restart in the middle of a header
        push_byte(8'h00);
        push_byte(8'hFF);
        push_str("$GLGSV,,,999*");
        push_str("$GPVTG1*,x");
        push_str("$GP$GPRMC,A*");
        wait_drained();

        // Long sentence: counter runs out and the block idles until the next '$'
        push_str("$GPVTG");
        for (int j = 0; j < 20; j++) begin
            push_byte(nsfp_pkg::CH_COMMA);
            for (int c = 0; c < 15; c++)
                push_byte(text_byte());
        end
        push_byte(nsfp_pkg::CH_STAR);

        for (int phase = 0; phase < 3; phase++) begin
            wait_drained();
            send_idle_pct  = (phase == 0) ? 25 : (phase == 1) ? 50 : 0;
            recv_stall_pct = (phase == 0) ? 50 : (phase == 1) ? 25 : 0;
            queued_bytes   = 0;
            while (queued_bytes < PHASE_ITEMS) begin
                if ($urandom_range(0, 9) == 0) begin
                    // noise burst
                    repeat ($urandom_range(1, 8))
                        push_byte(8'($urandom_range(0, 255)));
                end else begin
                    add_sentence();
                end
                // sender holds off until all results are in while the queued count sits just past half the phase
                if (queued_bytes >= PHASE_ITEMS / 2 && queued_bytes < PHASE_ITEMS / 2 + 40)
                    wait_drained();
                while (stream_q.size() > 64)
                    @(negedge i_clk);
            end
        end
        wait_drained();
        repeat (10) @(negedge i_clk);

        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
